// ===== design/adclcd_pkg.sv =====
`default_nettype none

package adclcd_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned HUND_W   = 9;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STEP_W   = 4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_W       = 1;
  localparam int unsigned CNT_W       = 2;

  localparam logic [BYTE_W-1:0] CMD_ROW1    = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_ROW2    = 8'hC0;
  localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] ASCII_V     = 8'h56;

  // position of each write inside the run of fifteen
  localparam logic [STEP_W-1:0] STEP_CNT_FIRST  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CNT_LAST   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ROW2       = 4'd8;
  localparam logic [STEP_W-1:0] STEP_VOLT_INT   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DOT        = 4'd10;
  localparam logic [STEP_W-1:0] STEP_VOLT_TENTH = 4'd11;
  localparam logic [STEP_W-1:0] STEP_VOLT_HUND  = 4'd12;
  localparam logic [STEP_W-1:0] STEP_SPACE      = 4'd13;
  localparam logic [STEP_W-1:0] STEP_UNIT       = 4'd14;

  typedef struct packed {
    logic [DIGIT_W-1:0] cnt_th;
    logic [DIGIT_W-1:0] cnt_h;
    logic [DIGIT_W-1:0] cnt_t;
    logic [DIGIT_W-1:0] cnt_o;
    logic [DIGIT_W-1:0] volt_int;
    logic [DIGIT_W-1:0] volt_tenth;
    logic [DIGIT_W-1:0] volt_hund;
  } digits_t;

  typedef struct packed {
    logic               push;
    logic               full;
  } queue_wr_t;

  // splits a value below 100 into tens and ones, tens by reciprocal multiply
  function automatic logic [2*DIGIT_W-1:0] split_tens(input logic [6:0] val);
    logic [14:0]        prod;
    logic [DIGIT_W-1:0] tens;
    logic [6:0]         ones;
    prod = 15'(val) * 15'd205;
    tens = prod[14:11];
    ones = val - (7'(tens) * 7'd10);
    return {tens, ones[DIGIT_W-1:0]};
  endfunction

  function automatic logic [BYTE_W-1:0] to_ascii(input logic [DIGIT_W-1:0] digit);
    return ASCII_ZERO + {4'd0, digit};
  endfunction

endpackage

`default_nettype wire

// ===== design/adclcd_front.sv =====
`default_nettype none

module adclcd_front (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire [adclcd_pkg::SAMPLE_W-1:0]  sample_i,
  output adclcd_pkg::queue_wr_t           wr_o,
  input  wire                             full_i,
  output adclcd_pkg::digits_t             digits_o
);
  import adclcd_pkg::*;

  logic                 a_valid_q, a_valid_d;
  logic [SAMPLE_W-1:0]  s_q;
  logic                 b_valid_q, b_valid_d;
  logic                 th_q;
  logic [DIGIT_W-1:0]   h_q;
  logic [SAMPLE_W-1:0]  r_q;
  logic [HUND_W-1:0]    hund_q;

  logic                 accept;
  logic                 b_adv;

  logic                 th;
  logic [SAMPLE_W-1:0]  rem;
  logic [15:0]          h_prod;
  logic [18:0]          n_prod;
  logic [HUND_W-1:0]    q0;
  logic [18:0]          n_rem;
  logic [HUND_W-1:0]    hund;

  logic [6:0]           r2;
  logic [2*DIGIT_W-1:0] cnt_lo;
  logic [14:0]          v_prod;
  logic [DIGIT_W-1:0]   v_int;
  logic [6:0]           v_rem;
  logic [2*DIGIT_W-1:0] volt_lo;

  assign b_adv      = !b_valid_q || !full_i;
  assign in_stall_o = a_valid_q && !b_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign wr_o.push  = b_valid_q && !full_i;
  assign wr_o.full  = full_i;

  // stage a: thousands, hundreds of the count and voltage in hundredths
  always_comb begin
    th     = (s_q >= 10'd1000);
    rem    = th ? (s_q - 10'd1000) : s_q;
    h_prod = 16'(rem) * 16'd41;
    n_prod = 19'(s_q) * 19'd500;
    q0     = n_prod[18:10];
    n_rem  = n_prod - (19'(q0) * 19'd1023);
    hund   = q0 + HUND_W'(n_rem >= 19'd1023);
  end

  // stage b: remaining digits
  always_comb begin
    r2      = 7'(r_q - ({6'd0, h_q} * 10'd100));
    cnt_lo  = split_tens(r2);
    v_prod  = 15'(hund_q) * 15'd41;
    v_int   = {1'b0, v_prod[14:12]};
    v_rem   = 7'(hund_q - ({5'd0, v_int} * 9'd100));
    volt_lo = split_tens(v_rem);
  end

  assign digits_o.cnt_th     = {3'd0, th_q};
  assign digits_o.cnt_h      = h_q;
  assign digits_o.cnt_t      = cnt_lo[2*DIGIT_W-1:DIGIT_W];
  assign digits_o.cnt_o      = cnt_lo[DIGIT_W-1:0];
  assign digits_o.volt_int   = v_int;
  assign digits_o.volt_tenth = volt_lo[2*DIGIT_W-1:DIGIT_W];
  assign digits_o.volt_hund  = volt_lo[DIGIT_W-1:0];

  always_comb begin
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (b_adv) begin
      a_valid_d = 1'b0;
    end else begin
      a_valid_d = a_valid_q;
    end
    b_valid_d = b_adv ? a_valid_q : b_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q <= sample_i;
    end
    if (b_adv && a_valid_q) begin
      th_q   <= th;
      h_q    <= h_prod[15:12];
      r_q    <= rem;
      hund_q <= hund;
    end
  end

endmodule

`default_nettype wire

// ===== design/adclcd_fifo.sv =====
`default_nettype none

module adclcd_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  adclcd_pkg::queue_wr_t  wr_i,
  input  adclcd_pkg::digits_t    data_i,
  output logic                   full_o,
  input  wire                    pop_i,
  output logic                   head_valid_o,
  output adclcd_pkg::digits_t    head_o
);
  import adclcd_pkg::*;

  digits_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o       = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i.push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i.push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i.push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/adclcd_back.sv =====
`default_nettype none

module adclcd_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          head_valid_i,
  input  adclcd_pkg::digits_t          head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [adclcd_pkg::BYTE_W-1:0] lcd_byte_o,
  output logic                         is_data_o,
  output logic                         last_o
);
  import adclcd_pkg::*;

  logic [STEP_W-1:0]  step_q, step_d;
  logic               valid_q, valid_d;
  logic [BYTE_W-1:0]  byte_q;
  logic               data_q;
  logic               last_q;

  logic               load;
  logic [DIGIT_W-1:0] cnt_digit;
  logic [BYTE_W-1:0]  byte_n;
  logic               data_n;

  assign load  = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o = load && (step_q == STEP_UNIT);

  always_comb begin
    case (step_q[2:1])
      2'd0:    cnt_digit = head_i.cnt_th;
      2'd1:    cnt_digit = head_i.cnt_h;
      2'd2:    cnt_digit = head_i.cnt_t;
      default: cnt_digit = head_i.cnt_o;
    endcase
  end

  always_comb begin
    byte_n = ASCII_SPACE;
    data_n = 1'b1;
    case (step_q) inside
      [STEP_CNT_FIRST:STEP_CNT_LAST]: begin
        if (!step_q[0]) begin
          byte_n = CMD_ROW1 | {6'd0, step_q[2:1]};
          data_n = 1'b0;
        end else begin
          byte_n = to_ascii(cnt_digit);
        end
      end
      STEP_ROW2: begin
        byte_n = CMD_ROW2;
        data_n = 1'b0;
      end
      STEP_VOLT_INT:   byte_n = to_ascii(head_i.volt_int);
      STEP_DOT:        byte_n = ASCII_DOT;
      STEP_VOLT_TENTH: byte_n = to_ascii(head_i.volt_tenth);
      STEP_VOLT_HUND:  byte_n = to_ascii(head_i.volt_hund);
      STEP_SPACE:      byte_n = ASCII_SPACE;
      STEP_UNIT:       byte_n = ASCII_V;
      default:         byte_n = ASCII_SPACE;
    endcase
  end

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q && out_stall_i;
    if (load) begin
      valid_d = 1'b1;
      step_d  = (step_q == STEP_UNIT) ? STEP_CNT_FIRST : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_CNT_FIRST;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_n;
      data_q <= data_n;
      last_q <= (step_q == STEP_UNIT);
    end
  end

  assign out_valid_o = valid_q;
  assign lcd_byte_o  = byte_q;
  assign is_data_o   = data_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== design/adc_sample_to_lcd_digits.sv =====
// adc sample to character-lcd write sequence
//
// input channel: in_valid_i / in_stall_o with sample_i, a 10-bit converter
// count. output channel: out_valid_o / out_stall_i with lcd_byte_o,
// is_data_o (0 command, 1 character) and last_o. an item moves on a rising
// edge where valid is high and stall is low.
// every input item yields fifteen writes: four cursor/digit pairs for the
// raw count on row one, then the row-two cursor and the voltage as "d.dd V".
// last_o marks the fifteenth write.
// the first write of a run is shown once the item has passed the input
// register, digit stage, queue and output register.
// throughput: one write per cycle while the receiver does not stall, set
// by the output sequencer; a two-entry queue lets the converter take up to
// three further items while a run is still being written.
// reset clears every valid flag, the write counter and the queue pointers
// and count; nothing else needs clearing. while the receiver stalls the
// output holds its write, the queue fills, and then in_stall_o rises.
`default_nettype none

module adc_sample_to_lcd_digits (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [adclcd_pkg::SAMPLE_W-1:0] sample_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [adclcd_pkg::BYTE_W-1:0] lcd_byte_o,
  output logic                          is_data_o,
  output logic                          last_o
);
  import adclcd_pkg::*;

  queue_wr_t wr;
  digits_t   wr_data;
  logic      full;
  logic      head_valid;
  digits_t   head;
  logic      pop;

  adclcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .wr_o       (wr),
    .full_i     (full),
    .digits_o   (wr_data)
  );

  adclcd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .data_i       (wr_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  adclcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .lcd_byte_o   (lcd_byte_o),
    .is_data_o    (is_data_o),
    .last_o       (last_o)
  );

  a_cmd_top_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_data_o |-> lcd_byte_o[7])
    else $error("command write without address bit");

  a_last_is_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> (lcd_byte_o == ASCII_V) && is_data_o)
    else $error("final write of a run is not the unit character");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.push |-> !full)
    else $error("queue written while full");

endmodule

`default_nettype wire
